>>> hdl/pcp_pkg.sv
// Package of the pinhole camera projection unit: shared constants, codes and item types.
// Depends on nothing; every other file of the unit imports it.
`timescale 1ns / 1ps

package pcp_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_W         = 64;
   localparam int DEN_W         = 32;
   localparam int QBITS         = 34;
   localparam int SQRT_STEPS    = 32;
   localparam int SQ_REM_W      = 35;

   localparam logic [2:0] FUNC_UNIT    = 3'd0;
   localparam logic [2:0] FUNC_DEPTH   = 3'd1;
   localparam logic [2:0] FUNC_PROJECT = 3'd2;
   localparam logic [2:0] FUNC_NORM    = 3'd3;
   localparam logic [2:0] FUNC_FRAME   = 3'd4;

   localparam logic [2:0] CSR_FOCAL_X  = 3'd0;
   localparam logic [2:0] CSR_FOCAL_Y  = 3'd1;
   localparam logic [2:0] CSR_CENTER_X = 3'd2;
   localparam logic [2:0] CSR_CENTER_Y = 3'd3;
   localparam logic [2:0] CSR_WIDTH    = 3'd4;
   localparam logic [2:0] CSR_HEIGHT   = 3'd5;
   localparam logic [2:0] CSR_PADDING  = 3'd6;

   localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
      logic signed [31:0] depth;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               in_frame;
      logic               div_error;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        focal_x;
      logic [31:0]        focal_y;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [15:0]        frame_width;
      logic [15:0]        frame_height;
      logic [7:0]         border_padding;
   } cfg_type;

   // One quotient lane before division.
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             neg;
   } lane_type;

   typedef lane_type [2:0] lane_set_type;

   // One quotient lane while the divider works on it.
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             neg;
      logic [DEN_W-1:0] rem;
      logic [QBITS-1:0] quo;
      logic             big;
      logic             dz;
   } div_lane_type;

   typedef div_lane_type [2:0] div_set_type;

   // Per-item control that rides alongside the lanes.
   typedef struct packed {
      logic signed [31:0] off_x;
      logic signed [31:0] off_y;
      logic signed [31:0] rz;
      logic               frame_hit;
      logic               z_active;
      logic               norm;
      logic               err;
   } meta_type;

endpackage

>>> hdl/pcp_front.sv
// Front stages of the projection unit: offsets, magnitudes, products and numerator selection.
// Depends on pcp_pkg.
`timescale 1ns / 1ps

module pcp_front
   import pcp_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  req_type            in_req,
   input  cfg_type            cfg,
   output logic               out_valid,
   output lane_set_type       out_lanes,
   output meta_type           out_meta,
   output logic [NUM_W-1:0]   out_sq
);

   localparam int EW = ((17 + FRAC_BITS > 32) ? 17 + FRAC_BITS : 32) + 1;
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   // Stage 1: differences and frame test.
   logic                 v1_ff, v1_in;
   req_type              r1_ff, r1_in;
   logic signed [32:0]   dx1_ff, dx1_in, dy1_ff, dy1_in;
   logic                 ins1_ff, ins1_in;
   logic signed [EW-1:0] lo_e, hx_e, hy_e, x_e, y_e;

   always_comb begin
      v1_in  = in_valid;
      r1_in  = in_req;
      dx1_in = 33'(in_req.in_x) - 33'(cfg.center_x);
      dy1_in = 33'(in_req.in_y) - 33'(cfg.center_y);
      lo_e   = EW'(cfg.border_padding) <<< FRAC_BITS;
      hx_e   = (EW'(cfg.frame_width) - EW'(cfg.border_padding)) <<< FRAC_BITS;
      hy_e   = (EW'(cfg.frame_height) - EW'(cfg.border_padding)) <<< FRAC_BITS;
      x_e    = EW'(in_req.in_x);
      y_e    = EW'(in_req.in_y);
      ins1_in = (in_req.func == FUNC_FRAME) && (x_e >= lo_e) && (x_e < hx_e)
                && (y_e >= lo_e) && (y_e < hy_e);
   end

   // Stage 2: magnitudes and signs.
   logic        v2_ff;
   req_type     r2_ff;
   logic        ins2_ff;
   logic [32:0] ax2_ff, ax2_in, ay2_ff, ay2_in;
   logic [31:0] mx2_ff, mx2_in, my2_ff, my2_in, mz2_ff, mz2_in, md2_ff, md2_in;
   logic        dxn2_ff, dyn2_ff, dxz2_ff, dxz2_in, dyz2_ff, dyz2_in;

   always_comb begin
      ax2_in  = dx1_ff[32] ? 33'(-dx1_ff) : 33'(dx1_ff);
      ay2_in  = dy1_ff[32] ? 33'(-dy1_ff) : 33'(dy1_ff);
      mx2_in  = r1_ff.in_x[31] ? (~r1_ff.in_x + 32'd1) : r1_ff.in_x;
      my2_in  = r1_ff.in_y[31] ? (~r1_ff.in_y + 32'd1) : r1_ff.in_y;
      mz2_in  = r1_ff.in_z[31] ? (~r1_ff.in_z + 32'd1) : r1_ff.in_z;
      md2_in  = r1_ff.depth[31] ? (~r1_ff.depth + 32'd1) : r1_ff.depth;
      dxz2_in = (dx1_ff != 33'sd0);
      dyz2_in = (dy1_ff != 33'sd0);
   end

   // Stage 3: one multiplier per lane.
   logic        v3_ff;
   req_type     r3_ff;
   logic        ins3_ff;
   logic [32:0] ax3_ff, ay3_ff;
   logic [31:0] mx3_ff, my3_ff, mz3_ff;
   logic        dxn3_ff, dyn3_ff, dxz3_ff, dyz3_ff;
   logic [63:0] px3_ff, px3_in, py3_ff, py3_in, pz3_ff, pz3_in;
   logic [32:0] ma_x, ma_y;
   logic [31:0] mb_x, mb_y;
   logic [64:0] prod_x, prod_y;

   always_comb begin
      case (r2_ff.func)
         FUNC_DEPTH: begin
            ma_x = ax2_ff;            mb_x = md2_ff;
            ma_y = ay2_ff;            mb_y = md2_ff;
         end
         FUNC_PROJECT: begin
            ma_x = {1'b0, cfg.focal_x}; mb_x = mx2_ff;
            ma_y = {1'b0, cfg.focal_y}; mb_y = my2_ff;
         end
         default: begin
            ma_x = {1'b0, mx2_ff};    mb_x = mx2_ff;
            ma_y = {1'b0, my2_ff};    mb_y = my2_ff;
         end
      endcase
      prod_x = ma_x * mb_x;
      prod_y = ma_y * mb_y;
      px3_in = prod_x[63:0];
      py3_in = prod_y[63:0];
      pz3_in = mz2_ff * mz2_ff;
   end

   // Stage 4: numerators, divisors, signs and the sum of squares.
   logic         v4_ff;
   lane_set_type l4_ff, l4_in;
   meta_type     m4_ff, m4_in;
   logic [63:0]  sq4_ff, sq4_in;
   logic         xn, yn, zn, dn;

   always_comb begin
      xn = r3_ff.in_x[31];
      yn = r3_ff.in_y[31];
      zn = r3_ff.in_z[31];
      dn = r3_ff.depth[31];
      sq4_in = px3_ff + py3_ff + pz3_ff;
      l4_in[0] = '{num: '0, den: 32'd1, neg: 1'b0};
      l4_in[1] = '{num: '0, den: 32'd1, neg: 1'b0};
      l4_in[2] = '{num: '0, den: 32'd1, neg: 1'b0};
      m4_in = '0;
      m4_in.frame_hit = ins3_ff;
      case (r3_ff.func)
         FUNC_UNIT: begin
            l4_in[0] = '{num: 64'(ax3_ff) << FRAC_BITS, den: cfg.focal_x, neg: dxn3_ff};
            l4_in[1] = '{num: 64'(ay3_ff) << FRAC_BITS, den: cfg.focal_y, neg: dyn3_ff};
            m4_in.rz = ONE;
         end
         FUNC_DEPTH: begin
            l4_in[0] = '{num: px3_ff, den: cfg.focal_x, neg: (dxn3_ff != dn) && dxz3_ff};
            l4_in[1] = '{num: py3_ff, den: cfg.focal_y, neg: (dyn3_ff != dn) && dyz3_ff};
            m4_in.rz = r3_ff.depth;
         end
         FUNC_PROJECT: begin
            l4_in[0] = '{num: px3_ff, den: mz3_ff, neg: xn != zn};
            l4_in[1] = '{num: py3_ff, den: mz3_ff, neg: yn != zn};
            m4_in.rz    = ONE;
            m4_in.off_x = cfg.center_x;
            m4_in.off_y = cfg.center_y;
         end
         FUNC_NORM: begin
            // The divisor is the root, filled in after the square root stages.
            l4_in[0] = '{num: 64'(mx3_ff) << FRAC_BITS, den: '0, neg: xn};
            l4_in[1] = '{num: 64'(my3_ff) << FRAC_BITS, den: '0, neg: yn};
            l4_in[2] = '{num: 64'(mz3_ff) << FRAC_BITS, den: '0, neg: zn};
            m4_in.z_active = 1'b1;
            m4_in.norm     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      r1_ff   <= r1_in;
      dx1_ff  <= dx1_in;
      dy1_ff  <= dy1_in;
      ins1_ff <= ins1_in;
      r2_ff   <= r1_ff;
      ins2_ff <= ins1_ff;
      ax2_ff  <= ax2_in;
      ay2_ff  <= ay2_in;
      mx2_ff  <= mx2_in;
      my2_ff  <= my2_in;
      mz2_ff  <= mz2_in;
      md2_ff  <= md2_in;
      dxn2_ff <= dx1_ff[32];
      dyn2_ff <= dy1_ff[32];
      dxz2_ff <= dxz2_in;
      dyz2_ff <= dyz2_in;
      r3_ff   <= r2_ff;
      ins3_ff <= ins2_ff;
      ax3_ff  <= ax2_ff;
      ay3_ff  <= ay2_ff;
      mx3_ff  <= mx2_ff;
      my3_ff  <= my2_ff;
      mz3_ff  <= mz2_ff;
      dxn3_ff <= dxn2_ff;
      dyn3_ff <= dyn2_ff;
      dxz3_ff <= dxz2_ff;
      dyz3_ff <= dyz2_ff;
      px3_ff  <= px3_in;
      py3_ff  <= py3_in;
      pz3_ff  <= pz3_in;
      l4_ff   <= l4_in;
      m4_ff   <= m4_in;
      sq4_ff  <= sq4_in;
   end

   assign out_valid = v4_ff;
   assign out_lanes = l4_ff;
   assign out_meta  = m4_ff;
   assign out_sq    = sq4_ff;

endmodule

>>> hdl/pcp_sqrt_stage.sv
// One stage of the pipelined integer square root: resolves one root bit per clock.
// Depends on pcp_pkg.
`timescale 1ns / 1ps

module pcp_sqrt_stage
   import pcp_pkg::*;
#(
   parameter int STEP = SQRT_STEPS - 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  lane_set_type        in_lanes,
   input  meta_type            in_meta,
   input  logic [NUM_W-1:0]    in_sq,
   input  logic [SQ_REM_W-1:0] in_rem,
   input  logic [DEN_W-1:0]    in_root,
   output logic                out_valid,
   output lane_set_type        out_lanes,
   output meta_type            out_meta,
   output logic [NUM_W-1:0]    out_sq,
   output logic [SQ_REM_W-1:0] out_rem,
   output logic [DEN_W-1:0]    out_root
);

   logic                valid_ff;
   lane_set_type        lanes_ff;
   meta_type            meta_ff;
   logic [NUM_W-1:0]    sq_ff;
   logic [SQ_REM_W-1:0] rem_ff, rem_in, raw, trial;
   logic [DEN_W-1:0]    root_ff, root_in;

   always_comb begin
      raw   = {in_rem[SQ_REM_W-3:0], in_sq[2*STEP+1 -: 2]};
      trial = SQ_REM_W'({in_root, 2'b01});
      if (raw >= trial) begin
         rem_in  = raw - trial;
         root_in = {in_root[DEN_W-2:0], 1'b1};
      end else begin
         rem_in  = raw;
         root_in = {in_root[DEN_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      lanes_ff <= in_lanes;
      meta_ff  <= in_meta;
      sq_ff    <= in_sq;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
   end

   assign out_valid = valid_ff;
   assign out_lanes = lanes_ff;
   assign out_meta  = meta_ff;
   assign out_sq    = sq_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

>>> hdl/pcp_div_stage.sv
// One stage of the pipelined restoring divider: one quotient bit per lane per clock.
// Depends on pcp_pkg.
`timescale 1ns / 1ps

module pcp_div_stage
   import pcp_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  div_set_type in_lanes,
   input  meta_type    in_meta,
   output logic        out_valid,
   output div_set_type out_lanes,
   output meta_type    out_meta
);

   localparam int BITPOS = QBITS - 1 - STEP;

   logic        valid_ff;
   div_set_type lanes_ff, lanes_in;
   meta_type    meta_ff;
   logic [DEN_W:0] raw [3];
   logic [DEN_W:0] diff [3];

   always_comb begin
      lanes_in = in_lanes;
      for (int i = 0; i < 3; i++) begin
         raw[i]  = {in_lanes[i].rem, in_lanes[i].num[BITPOS]};
         diff[i] = raw[i] - {1'b0, in_lanes[i].den};
         if (raw[i] >= {1'b0, in_lanes[i].den}) begin
            lanes_in[i].rem = diff[i][DEN_W-1:0];
            lanes_in[i].quo = {in_lanes[i].quo[QBITS-2:0], 1'b1};
         end else begin
            lanes_in[i].rem = raw[i][DEN_W-1:0];
            lanes_in[i].quo = {in_lanes[i].quo[QBITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      lanes_ff <= lanes_in;
      meta_ff  <= in_meta;
   end

   assign out_valid = valid_ff;
   assign out_lanes = lanes_ff;
   assign out_meta  = meta_ff;

endmodule

>>> hdl/pcp_back.sv
// Output stage of the projection unit: applies sign and offset, saturates, registers the item.
// Depends on pcp_pkg.
`timescale 1ns / 1ps

module pcp_back
   import pcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  div_set_type in_lanes,
   input  meta_type    in_meta,
   output logic        out_valid,
   output rsp_type     out_rsp
);

   localparam logic [QBITS:0] BIG_Q = (QBITS+1)'(1) << QBITS;

   function automatic logic signed [31:0] lane_result(div_lane_type l, logic signed [31:0] off);
      logic [QBITS:0]        qe;
      logic signed [QBITS+1:0] sq;
      logic signed [QBITS+2:0] t;
      logic signed [31:0]    r;
      if (l.big) qe = BIG_Q;
      else if (l.dz) qe = '0;
      else qe = {1'b0, l.quo};
      sq = l.neg ? -$signed({1'b0, qe}) : $signed({1'b0, qe});
      t  = (QBITS+3)'(sq) + (QBITS+3)'(off);
      if (t > (QBITS+3)'(32'sh7FFF_FFFF)) r = 32'sh7FFF_FFFF;
      else if (t < (QBITS+3)'(-33'sh8000_0000)) r = 32'sh8000_0000;
      else r = t[31:0];
      return r;
   endfunction

   logic    valid_ff;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.out_x     = lane_result(in_lanes[0], in_meta.off_x);
      rsp_in.out_y     = lane_result(in_lanes[1], in_meta.off_y);
      rsp_in.out_z     = in_meta.z_active ? lane_result(in_lanes[2], 32'sd0) : in_meta.rz;
      rsp_in.in_frame  = in_meta.frame_hit;
      rsp_in.div_error = in_meta.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

>>> hdl/pinhole_camera_projection_unit_core.sv
// Top level of the pinhole camera projection unit: configuration registers and the pipeline.
// Depends on pcp_pkg, pcp_front, pcp_sqrt_stage, pcp_div_stage and pcp_back.
`timescale 1ns / 1ps

// The unit takes one item in every clock cycle while busy is low and returns exactly one result
// item for each, in order, after it passes four front stages (offsets, magnitudes, one
// multiplier per lane, numerator selection), 32 square root stages that resolve one root
// bit each, one divider setup stage, 34 divider stages that resolve one quotient bit each,
// and one output stage. The depth of the pipeline is set by the bit-per-stage square root
// and divider. busy is high only during reset. A result is shown for a single cycle
// with rsp_valid and the receiver must take it then; there is no way to hold it off, and the
// pipeline never stalls. Configuration writes are always accepted and should only be made
// while no item is in flight.

module pinhole_camera_projection_unit_core
   import pcp_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int LATENCY = 4 + SQRT_STEPS + 1 + QBITS + 1;

   // Configuration registers.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FOCAL_X:  cfg_in.focal_x        = csr_data;
            CSR_FOCAL_Y:  cfg_in.focal_y        = csr_data;
            CSR_CENTER_X: cfg_in.center_x       = csr_data;
            CSR_CENTER_Y: cfg_in.center_y       = csr_data;
            CSR_WIDTH:    cfg_in.frame_width    = csr_data[15:0];
            CSR_HEIGHT:   cfg_in.frame_height   = csr_data[15:0];
            CSR_PADDING:  cfg_in.border_padding = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{focal_x: FOCAL_RESET, focal_y: FOCAL_RESET, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = reset;

   // Front stages.
   logic         accept;
   logic         sq_valid [SQRT_STEPS+1];
   lane_set_type sq_lanes [SQRT_STEPS+1];
   meta_type     sq_meta  [SQRT_STEPS+1];
   logic [NUM_W-1:0]    sq_val  [SQRT_STEPS+1];
   logic [SQ_REM_W-1:0] sq_rem  [SQRT_STEPS+1];
   logic [DEN_W-1:0]    sq_root [SQRT_STEPS+1];

   assign accept = start && !busy;

   pcp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_data),
      .cfg       (cfg_ff),
      .out_valid (sq_valid[0]),
      .out_lanes (sq_lanes[0]),
      .out_meta  (sq_meta[0]),
      .out_sq    (sq_val[0])
   );

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   // Square root of the sum of squares, most significant root bit first. Only normalize
   // items use the root, but every item walks the same stages so order and latency hold.
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      pcp_sqrt_stage #(.STEP(SQRT_STEPS - 1 - k)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[k]),
         .in_lanes  (sq_lanes[k]),
         .in_meta   (sq_meta[k]),
         .in_sq     (sq_val[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .out_valid (sq_valid[k+1]),
         .out_lanes (sq_lanes[k+1]),
         .out_meta  (sq_meta[k+1]),
         .out_sq    (sq_val[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1])
      );
   end

   // Divider setup: pick the divisor, flag a zero divisor, and catch quotients too large
   // to resolve in the stages below; those saturate downstream in any case.
   logic        dv_valid [QBITS+1];
   div_set_type dv_lanes [QBITS+1];
   meta_type    dv_meta  [QBITS+1];

   logic        prep_valid_ff;
   div_set_type prep_lanes_ff, prep_lanes_in;
   meta_type    prep_meta_ff, prep_meta_in;
   logic [DEN_W-1:0] den_sel [3];

   always_comb begin
      prep_meta_in = sq_meta[SQRT_STEPS];
      prep_meta_in.err = 1'b0;
      for (int i = 0; i < 3; i++) begin
         den_sel[i] = sq_meta[SQRT_STEPS].norm ? sq_root[SQRT_STEPS] : sq_lanes[SQRT_STEPS][i].den;
         prep_lanes_in[i].num = sq_lanes[SQRT_STEPS][i].num;
         prep_lanes_in[i].den = den_sel[i];
         prep_lanes_in[i].neg = sq_lanes[SQRT_STEPS][i].neg;
         prep_lanes_in[i].quo = '0;
         prep_lanes_in[i].dz  = (den_sel[i] == '0);
         if (den_sel[i] == '0) begin
            prep_lanes_in[i].big = (sq_lanes[SQRT_STEPS][i].num != '0);
            prep_lanes_in[i].rem = '0;
            prep_meta_in.err     = 1'b1;
         end else begin
            prep_lanes_in[i].big =
               (DEN_W'(sq_lanes[SQRT_STEPS][i].num[NUM_W-1:QBITS]) >= den_sel[i]);
            prep_lanes_in[i].rem = DEN_W'(sq_lanes[SQRT_STEPS][i].num[NUM_W-1:QBITS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= sq_valid[SQRT_STEPS];
      end
      prep_lanes_ff <= prep_lanes_in;
      prep_meta_ff  <= prep_meta_in;
   end

   assign dv_valid[0] = prep_valid_ff;
   assign dv_lanes[0] = prep_lanes_ff;
   assign dv_meta[0]  = prep_meta_ff;

   // Three lanes of restoring division, one quotient bit per stage.
   for (genvar k = 0; k < QBITS; k++) begin : g_div
      pcp_div_stage #(.STEP(k)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[k]),
         .in_lanes  (dv_lanes[k]),
         .in_meta   (dv_meta[k]),
         .out_valid (dv_valid[k+1]),
         .out_lanes (dv_lanes[k+1]),
         .out_meta  (dv_meta[k+1])
      );
   end

   pcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid[QBITS]),
      .in_lanes  (dv_lanes[QBITS]),
      .in_meta   (dv_meta[QBITS]),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   // An accepted item comes out at the pipeline latency, and nothing else does.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("item did not come out at the pipeline latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##LATENCY !rsp_valid)
      else $error("result appeared without an accepted item");

   // The frame test only divides zero by one, so it cannot report a divisor error.
   a_frame_no_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.in_frame) |-> !rsp_data.div_error)
      else $error("frame test result carries a divisor error");

endmodule
